/* rtl/gdas_pkg.sv */
`timescale 1ns / 1ps

package gdas_pkg;

  localparam int LAST_YEAR  = 9999;
  localparam int COUNT_BITS = 16;
  localparam int FIRST_YEAR = 1900;

  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_IN_W  = 14;
  localparam int CNT_IN_W   = 16;

  localparam int CNT_W      = (COUNT_BITS < CNT_IN_W) ? COUNT_BITS : CNT_IN_W;
  // signed day accumulator: +/- (2^CNT_W + 31)
  localparam int ACC_W      = ((CNT_W > 6) ? CNT_W : 6) + 2;
  localparam int YR_W       = ($clog2(LAST_YEAR + 2) > YEAR_IN_W) ?
                              $clog2(LAST_YEAR + 2) : YEAR_IN_W;
  localparam int M400_W     = 9;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_DATE  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_DOWN,
    ST_UP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [DAY_W-1:0]     in_day;
    logic [MON_W-1:0]     in_month;
    logic [YEAR_IN_W-1:0] in_year;
    logic [CNT_IN_W-1:0]  day_count;
    logic                 go_back;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]     out_day;
    logic [MON_W-1:0]     out_month;
    logic [YEAR_IN_W-1:0] out_year;
    status_t              status;
  } rsp_t;

  function automatic logic is_leap(logic [1:0] y_lo, logic [M400_W-1:0] m400);
    logic c100;
    c100 = (m400 == M400_W'(100)) || (m400 == M400_W'(200)) ||
           (m400 == M400_W'(300));
    return (y_lo == 2'd0) && ((m400 == '0) || !c100);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(logic [MON_W-1:0] m, logic leap);
    logic [DAY_W-1:0] d;
    case (m) inside
      4'd2:                   d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* rtl/gregorian_date_add_subtract.sv */
`timescale 1ns / 1ps

// Gregorian date offset. Takes a date, a day count and a direction and returns
// the date that many days later or earlier, with status (ok, invalid input date,
// clamped to 1 Jan 1900, or past the last year with the input date held). One
// request at a time: req_ready is high only while idle. A request first reduces
// the year mod 400, subtracting 400 per cycle, then checks the input date, then
// runs the month carry loop (one add/subtract of a month length per cycle),
// borrowing months downward and then carrying upward, and loads the rsp register
// once it is empty or being read. A finished result waits in the rsp register,
// so a new request is taken while it is held.
module gregorian_date_add_subtract (
  input  logic           clk,
  input  logic           rst,
  input  gdas_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_ready,
  output gdas_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_ready
);

  gdas_pkg::state_t state, state_next;

  logic [gdas_pkg::DAY_W-1:0]      d0;
  logic [gdas_pkg::MON_W-1:0]      m0;
  logic [gdas_pkg::YEAR_IN_W-1:0]  y0;
  logic [gdas_pkg::CNT_W-1:0]      cnt;
  logic                            back;
  logic [gdas_pkg::YEAR_IN_W-1:0]  rem;
  logic                            bad;
  logic signed [gdas_pkg::ACC_W-1:0] day;
  logic [gdas_pkg::MON_W-1:0]      mon;
  logic [gdas_pkg::YR_W-1:0]       yr;
  logic [gdas_pkg::M400_W-1:0]     m400;

  logic                            accept;
  logic                            load;
  logic                            rem_big;
  logic                            leap_in;
  logic [gdas_pkg::DAY_W-1:0]      md_in;
  logic                            invalid;
  logic                            leap_cur;
  logic [gdas_pkg::DAY_W-1:0]      md_cur;
  logic [gdas_pkg::MON_W-1:0]      prev_mon, nxt_mon;
  logic [gdas_pkg::YR_W-1:0]       prev_yr, nxt_yr;
  logic [gdas_pkg::M400_W-1:0]     prev_m400, nxt_m400;
  logic [gdas_pkg::DAY_W-1:0]      md_prev;
  logic                            down_go, up_go;
  logic signed [gdas_pkg::ACC_W-1:0] d0_ext, cnt_ext, md_cur_ext, md_prev_ext;
  gdas_pkg::rsp_t                  result;

  assign accept  = req_valid && req_ready;
  assign rem_big = rem >= gdas_pkg::YEAR_IN_W'(400);

  assign leap_in = gdas_pkg::is_leap(y0[1:0], rem[gdas_pkg::M400_W-1:0]);
  assign md_in   = gdas_pkg::month_days(m0, leap_in);
  assign invalid = (m0 < 4'd1) || (m0 > 4'd12) ||
                   (y0 < gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR)) ||
                   (d0 < 5'd1) || (d0 > md_in);

  assign leap_cur = gdas_pkg::is_leap(yr[1:0], m400);
  assign md_cur   = gdas_pkg::month_days(mon, leap_cur);

  always_comb begin
    if (mon == 4'd1) begin
      prev_mon  = 4'd12;
      prev_yr   = yr - gdas_pkg::YR_W'(1);
      prev_m400 = (m400 == '0) ? gdas_pkg::M400_W'(399) : m400 - gdas_pkg::M400_W'(1);
    end else begin
      prev_mon  = mon - 4'd1;
      prev_yr   = yr;
      prev_m400 = m400;
    end
    if (mon == 4'd12) begin
      nxt_mon  = 4'd1;
      nxt_yr   = yr + gdas_pkg::YR_W'(1);
      nxt_m400 = (m400 == gdas_pkg::M400_W'(399)) ? '0 : m400 + gdas_pkg::M400_W'(1);
    end else begin
      nxt_mon  = mon + 4'd1;
      nxt_yr   = yr;
      nxt_m400 = m400;
    end
  end

  assign md_prev = gdas_pkg::month_days(prev_mon, gdas_pkg::is_leap(prev_yr[1:0], prev_m400));

  assign d0_ext      = $signed({{(gdas_pkg::ACC_W-gdas_pkg::DAY_W){1'b0}}, d0});
  assign cnt_ext     = $signed({{(gdas_pkg::ACC_W-gdas_pkg::CNT_W){1'b0}}, cnt});
  assign md_cur_ext  = $signed({{(gdas_pkg::ACC_W-gdas_pkg::DAY_W){1'b0}}, md_cur});
  assign md_prev_ext = $signed({{(gdas_pkg::ACC_W-gdas_pkg::DAY_W){1'b0}}, md_prev});

  assign down_go = (day < $signed(gdas_pkg::ACC_W'(1))) &&
                   (yr >= gdas_pkg::YR_W'(gdas_pkg::FIRST_YEAR));
  assign up_go   = (day > md_cur_ext) && (yr <= gdas_pkg::YR_W'(gdas_pkg::LAST_YEAR));

  always_comb begin
    if (bad) begin
      result = '{out_day: 5'd1, out_month: 4'd1,
                 out_year: gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR),
                 status: gdas_pkg::STAT_BAD_DATE};
    end else if (yr < gdas_pkg::YR_W'(gdas_pkg::FIRST_YEAR)) begin
      result = '{out_day: 5'd1, out_month: 4'd1,
                 out_year: gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR),
                 status: gdas_pkg::STAT_UNDERFLOW};
    end else if (yr > gdas_pkg::YR_W'(gdas_pkg::LAST_YEAR)) begin
      result = '{out_day: d0, out_month: m0, out_year: y0,
                 status: gdas_pkg::STAT_OVERFLOW};
    end else begin
      result = '{out_day: day[gdas_pkg::DAY_W-1:0], out_month: mon,
                 out_year: yr[gdas_pkg::YEAR_IN_W-1:0], status: gdas_pkg::STAT_OK};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gdas_pkg::ST_IDLE:   if (req_valid) state_next = gdas_pkg::ST_MOD;
      gdas_pkg::ST_MOD:    if (!rem_big) state_next = gdas_pkg::ST_CHECK;
      gdas_pkg::ST_CHECK:  state_next = invalid ? gdas_pkg::ST_FINISH : gdas_pkg::ST_DOWN;
      gdas_pkg::ST_DOWN:   if (!down_go) state_next = gdas_pkg::ST_UP;
      gdas_pkg::ST_UP:     if (!up_go) state_next = gdas_pkg::ST_FINISH;
      gdas_pkg::ST_FINISH: if (!rsp_valid || rsp_ready) state_next = gdas_pkg::ST_IDLE;
      default:             state_next = gdas_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    load      = 1'b0;
    unique case (state)
      gdas_pkg::ST_IDLE:   req_ready = 1'b1;
      gdas_pkg::ST_FINISH: load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdas_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d0   <= req.in_day;
      m0   <= req.in_month;
      y0   <= req.in_year;
      cnt  <= req.day_count[gdas_pkg::CNT_W-1:0];
      back <= req.go_back;
      rem  <= req.in_year;
    end
    if (state == gdas_pkg::ST_MOD && rem_big) begin
      rem <= rem - gdas_pkg::YEAR_IN_W'(400);
    end
    if (state == gdas_pkg::ST_CHECK) begin
      bad  <= invalid;
      mon  <= m0;
      yr   <= gdas_pkg::YR_W'(y0);
      m400 <= rem[gdas_pkg::M400_W-1:0];
      day  <= back ? d0_ext - cnt_ext : d0_ext + cnt_ext;
    end
    if (state == gdas_pkg::ST_DOWN && down_go) begin
      mon  <= prev_mon;
      yr   <= prev_yr;
      m400 <= prev_m400;
      day  <= day + md_prev_ext;
    end
    if (state == gdas_pkg::ST_UP && up_go) begin
      mon  <= nxt_mon;
      yr   <= nxt_yr;
      m400 <= nxt_m400;
      day  <= day - md_cur_ext;
    end
    if (load) begin
      rsp <= result;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("request taken while busy");

  a_rsp_date_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.out_day >= 5'd1) && (rsp.out_month >= 4'd1) &&
                  (rsp.out_month <= 4'd12) &&
                  (rsp.out_year >= gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR)))
    else $error("result date out of range");

  a_bad_date_default: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == gdas_pkg::STAT_BAD_DATE) |->
      (rsp.out_day == 5'd1) && (rsp.out_month == 4'd1) &&
      (rsp.out_year == gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR)))
    else $error("invalid date result not 1 Jan 1900");

  a_month_legal: assert property (@(posedge clk) disable iff (rst)
    (state == gdas_pkg::ST_DOWN || state == gdas_pkg::ST_UP) |->
      (mon >= 4'd1) && (mon <= 4'd12))
    else $error("month out of range during carry");

  a_mod_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == gdas_pkg::ST_CHECK) |-> !rem_big)
    else $error("year mod 400 not reduced");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst = 1'b1;
  gdas_pkg::req_t req = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  gdas_pkg::rsp_t rsp;
  logic rsp_valid;
  logic rsp_ready = 1'b0;

  bit   idling = 1'b1;
  int   errors, sent, checked, n_bad, n_under, n_over;
  gdas_pkg::rsp_t pending_dates[$];

  gregorian_date_add_subtract DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[gregorian_date_add_subtract] ERROR");
    $finish;
  end

  function automatic bit leap_year(int y);
    return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
  endfunction

  function automatic int days_in(int m, int y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic gdas_pkg::rsp_t shift_date(gdas_pkg::req_t r);
    int   d0, m0, y0, cnt, day, mon, yr;
    gdas_pkg::rsp_t o;
    d0  = int'(r.in_day);
    m0  = int'(r.in_month);
    y0  = int'(r.in_year);
    cnt = int'(longint'(r.day_count) & ((longint'(1) << gdas_pkg::COUNT_BITS) - 1));
    o   = '0;
    if (m0 < 1 || m0 > 12 || y0 < gdas_pkg::FIRST_YEAR || d0 < 1 ||
        d0 > days_in(m0, y0)) begin
      o.out_day   = 5'd1;
      o.out_month = 4'd1;
      o.out_year  = gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR);
      o.status    = gdas_pkg::STAT_BAD_DATE;
      return o;
    end
    day = r.go_back ? d0 - cnt : d0 + cnt;
    mon = m0;
    yr  = y0;
    while (day < 1 && yr >= gdas_pkg::FIRST_YEAR) begin
      if (mon == 1) begin
        mon = 12;
        yr--;
      end else begin
        mon--;
      end
      day += days_in(mon, yr);
    end
    while (day > days_in(mon, yr) && yr <= gdas_pkg::LAST_YEAR) begin
      day -= days_in(mon, yr);
      if (mon == 12) begin
        mon = 1;
        yr++;
      end else begin
        mon++;
      end
    end
    if (yr < gdas_pkg::FIRST_YEAR) begin
      o.out_day   = 5'd1;
      o.out_month = 4'd1;
      o.out_year  = gdas_pkg::YEAR_IN_W'(gdas_pkg::FIRST_YEAR);
      o.status    = gdas_pkg::STAT_UNDERFLOW;
    end else if (yr > gdas_pkg::LAST_YEAR) begin
      o.out_day   = gdas_pkg::DAY_W'(d0);
      o.out_month = gdas_pkg::MON_W'(m0);
      o.out_year  = gdas_pkg::YEAR_IN_W'(y0);
      o.status    = gdas_pkg::STAT_OVERFLOW;
    end else begin
      o.out_day   = gdas_pkg::DAY_W'(day);
      o.out_month = gdas_pkg::MON_W'(mon);
      o.out_year  = gdas_pkg::YEAR_IN_W'(yr);
      o.status    = gdas_pkg::STAT_OK;
    end
    return o;
  endfunction

  function automatic gdas_pkg::req_t make_req(int d, int m, int y, int cnt, bit back);
    gdas_pkg::req_t r;
    r.in_day    = gdas_pkg::DAY_W'(d);
    r.in_month  = gdas_pkg::MON_W'(m);
    r.in_year   = gdas_pkg::YEAR_IN_W'(y);
    r.day_count = gdas_pkg::CNT_IN_W'(cnt);
    r.go_back   = back;
    return r;
  endfunction

  task automatic send_request(input gdas_pkg::req_t r);
    if (idling && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_dates.push_back(shift_date(r));
    sent++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    gdas_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0d/%0d/%0d status %0d", $time,
                 rsp.out_day, rsp.out_month, rsp.out_year, rsp.status);
      end else begin
        want = pending_dates.pop_front();
        compare_field("out_day", int'(want.out_day), int'(rsp.out_day));
        compare_field("out_month", int'(want.out_month), int'(rsp.out_month));
        compare_field("out_year", int'(want.out_year), int'(rsp.out_year));
        compare_field("status", int'(want.status), int'(rsp.status));
        checked++;
        case (want.status)
          gdas_pkg::STAT_BAD_DATE:  n_bad++;
          gdas_pkg::STAT_UNDERFLOW: n_under++;
          gdas_pkg::STAT_OVERFLOW:  n_over++;
          default: ;
        endcase
      end
    end
    rsp_ready <= !idling || $urandom_range(99) >= 10;
  end

  task automatic test_zero_count();
    send_request(make_req(15, 6, 2024, 0, 1'b0));
    send_request(make_req(31, 12, 9999, 0, 1'b1));
    send_request(make_req(1, 1, 1900, 0, 1'b1));
  endtask

  task automatic test_bad_dates();
    send_request(make_req(10, 0, 2000, 5, 1'b0));
    send_request(make_req(10, 13, 2000, 5, 1'b0));
    send_request(make_req(31, 15, 16383, 65535, 1'b1));
    send_request(make_req(31, 12, 1899, 1, 1'b0));
    send_request(make_req(1, 1, 0, 1, 1'b0));
    send_request(make_req(0, 5, 2010, 3, 1'b1));
    send_request(make_req(31, 4, 2023, 1, 1'b0));
    send_request(make_req(29, 2, 1900, 1, 1'b0));
    send_request(make_req(30, 2, 2000, 1, 1'b0));
  endtask

  task automatic test_leap_rules();
    send_request(make_req(28, 2, 2000, 1, 1'b0));
    send_request(make_req(28, 2, 2100, 1, 1'b0));
    send_request(make_req(28, 2, 2024, 1, 1'b0));
    send_request(make_req(1, 3, 2023, 1, 1'b1));
    send_request(make_req(29, 2, 2000, 365, 1'b0));
  endtask

  task automatic test_limits();
    send_request(make_req(1, 1, 1900, 1, 1'b1));
    send_request(make_req(5, 3, 1900, 65535, 1'b1));
    send_request(make_req(31, 12, 9999, 1, 1'b0));
    send_request(make_req(1, 1, 9990, 65535, 1'b0));
    send_request(make_req(31, 1, 16383, 0, 1'b0));
    send_request(make_req(3, 1, 10000, 5, 1'b1));
    send_request(make_req(31, 12, 9999, 65535, 1'b1));
  endtask

  task automatic test_random(int n);
    gdas_pkg::req_t r;
    int   pick, y, m, c, cnt;
    for (int i = 0; i < n; i++) begin
      idling = !(i >= 100 && i < 160);
      pick   = $urandom_range(99);
      if (pick < 12) begin
        r = make_req($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                     $urandom_range(65535), 1'($urandom_range(1)));
      end else begin
        if (pick < 24) y = $urandom_range(1925, 1900);
        else if (pick < 36) y = $urandom_range(9999, 9975);
        else y = $urandom_range(9999, 1900);
        m   = $urandom_range(12, 1);
        c   = $urandom_range(99);
        cnt = c < 70 ? $urandom_range(400) : (c < 92 ? $urandom_range(6000)
                                                    : $urandom_range(65535));
        r   = make_req($urandom_range(days_in(m, y), 1), m, y, cnt,
                       1'($urandom_range(1)));
      end
      send_request(r);
    end
    idling = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_count();
    test_bad_dates();
    test_leap_rules();
    test_limits();
    // hold off until the directed requests have all come back
    wait_for_results();
    test_random(245);
    wait_for_results();
    repeat (20) @(posedge clk);
    $display("%0d requests sent, %0d results checked", sent, checked);
    $display("%0d invalid dates, %0d clamped to 1900, %0d past last year",
             n_bad, n_under, n_over);
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("[gregorian_date_add_subtract] OK");
    end else begin
      $display("[gregorian_date_add_subtract] ERROR");
    end
    $finish;
  end

endmodule

/* gregorian_date_add_subtract.f */
rtl/gdas_pkg.sv
rtl/gregorian_date_add_subtract.sv
test/tb_top.sv
